>>> rtl/ethertype_tag_skip_filter_macros.svh
// assertion macros shared by the ethertype tag skip filter modules
// depends on nothing; modules that check themselves include this file
`ifndef ETHERTYPE_TAG_SKIP_FILTER_MACROS_SVH
`define ETHERTYPE_TAG_SKIP_FILTER_MACROS_SVH

// condition holds at every clock edge outside reset
`define ETFS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ETFS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ETFS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/etfs_pkg.sv
// types, constants and match helpers for the ethertype tag skip filter
// used by every module of the block; depends on nothing
package etfs_pkg;

   // sizing
   localparam int MAX_SCAN_OFFSET = 9;
   localparam int MAX_FRAME_BYTES = 2047;
   localparam int HDR_DEPTH       = 18 + MAX_SCAN_OFFSET;
   localparam int WIN_IDX_W       = $clog2(HDR_DEPTH);
   localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
   localparam int OFFSET_W        = 4;
   localparam int LENGTH_W        = 11;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   // header positions and byte codes
   localparam int TYPE_POS     = 12;
   localparam int IP_VER_POS   = 14;
   localparam int ARP_PROT_POS = 16;
   localparam logic [7:0] ETH_TYPE_HI  = 8'h08;
   localparam logic [7:0] ETH_TYPE_IP  = 8'h00;
   localparam logic [7:0] ETH_TYPE_ARP = 8'h06;
   localparam logic [7:0] IPV4_VER_IHL = 8'h45;
   localparam logic [7:0] ARP_PROT_IP  = 8'h08;
   localparam logic [7:0] ARP_PROT_ALT = 8'hF0;
   localparam logic [7:0] ARP_PROT_LO  = 8'h00;

   typedef logic [HDR_DEPTH-1:0][7:0] window_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                accept;
      logic [OFFSET_W-1:0] tag_offset;
      logic [LENGTH_W-1:0] frame_length;
   } rsp_type;

   // one finished frame handed from front to back
   typedef struct packed {
      logic [MAX_SCAN_OFFSET:0] match_vec;
      logic [COUNT_W-1:0]       byte_count;
   } verdict_job_type;

   // header byte at a position, zero past the window
   function automatic logic [7:0] win_at(window_type win, int pos);
      logic [7:0] b;
      b = 8'h00;
      if (pos < HDR_DEPTH) begin
         b = win[pos[WIN_IDX_W-1:0]];
      end
      return b;
   endfunction

   // ipv4 or arp signature at tag offset k
   function automatic logic match_at(window_type win, int k);
      logic ipv4_hit;
      logic arp_hit;
      logic [7:0] p0;
      ipv4_hit = (win_at(win, TYPE_POS + k) == ETH_TYPE_HI) &&
                 (win_at(win, TYPE_POS + 1 + k) == ETH_TYPE_IP) &&
                 (win_at(win, IP_VER_POS + k) == IPV4_VER_IHL);
      p0 = win_at(win, ARP_PROT_POS + k);
      arp_hit = (win_at(win, TYPE_POS + k) == ETH_TYPE_HI) &&
                (win_at(win, TYPE_POS + 1 + k) == ETH_TYPE_ARP) &&
                ((p0 == ARP_PROT_IP) || (p0 == ARP_PROT_ALT)) &&
                (win_at(win, ARP_PROT_POS + 1 + k) == ARP_PROT_LO);
      return ipv4_hit || arp_hit;
   endfunction

endpackage

>>> rtl/ethertype_tag_skip_filter.sv
// Ethertype tag skip filter. Takes one frame byte per cycle unless the job queue is full
// (req_data.last_byte marks the frame end), one-byte frames included, and gives one verdict
// per frame: accept for IPv4 (08 00 45) or ARP (08 06 .. 08 00 / F0 00) at tag offset 0,
// then the remembered offset, then 1 to 9, with the tag offset and the frame length minus
// that offset. The verdict goes through the job queue and the result register. The rate is
// set by the front window write and compares, one byte per cycle; a two-entry job queue
// and the result register let byte intake continue while a verdict waits to be popped,
// until the queue fills. Moving the MAC addresses past the tag is left to the consumer.
// depends on etfs_pkg, etfs_front, etfs_queue, etfs_back
module ethertype_tag_skip_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  etfs_pkg::req_type  req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output etfs_pkg::rsp_type  rsp_data
);

   logic                      byte_valid;
   logic                      job_push;
   logic                      job_full;
   logic                      job_pop;
   logic                      job_empty;
   etfs_pkg::verdict_job_type front_job;
   etfs_pkg::verdict_job_type back_job;

   // an item is accepted whenever the job queue has room
   assign req_full   = job_full;
   assign byte_valid = req_push && !job_full;

   etfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_in    (req_data),
      .job_push   (job_push),
      .job_out    (front_job)
   );

   etfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (front_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (back_job),
      .empty     (job_empty)
   );

   etfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_in    (back_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/etfs_front.sv
// front part: takes frame bytes, keeps the header window and byte count,
// and on the final byte emits the per-offset match vector; uses etfs_pkg
module etfs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_valid,
   input  etfs_pkg::req_type          byte_in,
   output logic                       job_push,
   output etfs_pkg::verdict_job_type  job_out
);

   logic [etfs_pkg::COUNT_W-1:0] count_ff, count_in;
   etfs_pkg::window_type         window_ff, window_in;
   etfs_pkg::window_type         view;
   logic [etfs_pkg::COUNT_W-1:0] count_sat;

   // new byte lands at the current count; bytes past it from older frames are masked
   always_comb begin
      for (int i = 0; i < etfs_pkg::HDR_DEPTH; i++) begin
         window_in[i] = (count_ff == etfs_pkg::COUNT_W'(i)) ? byte_in.data_byte : window_ff[i];
         view[i]      = (count_ff >= etfs_pkg::COUNT_W'(i)) ? window_in[i] : 8'h00;
      end
   end

   // saturating byte count including this byte
   assign count_sat = (count_ff == etfs_pkg::COUNT_W'(etfs_pkg::MAX_FRAME_BYTES)) ?
                      count_ff : count_ff + etfs_pkg::COUNT_W'(1);

   always_comb begin
      count_in = count_ff;
      if (byte_valid) begin
         count_in = byte_in.last_byte ? '0 : count_sat;
      end
   end

   // parallel signature compares, one per tag offset
   for (genvar k = 0; k <= etfs_pkg::MAX_SCAN_OFFSET; k++) begin : g_match
      assign job_out.match_vec[k] = etfs_pkg::match_at(view, k);
   end

   assign job_out.byte_count = count_sat;
   assign job_push           = byte_valid && byte_in.last_byte;

   // count state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // window bytes, validity follows the count
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         window_ff <= window_in;
      end
   end

endmodule

>>> rtl/etfs_queue.sv
// short job queue between front and back so each side stalls on its own
// holds etfs_pkg::verdict_job_type entries in flops
`include "ethertype_tag_skip_filter_macros.svh"
module etfs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  etfs_pkg::verdict_job_type  push_data,
   output logic                       full,
   input  logic                       pop,
   output etfs_pkg::verdict_job_type  pop_data,
   output logic                       empty
);

   etfs_pkg::verdict_job_type entries_ff [etfs_pkg::QUEUE_DEPTH];
   logic [etfs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [etfs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [etfs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign full     = (count_ff == etfs_pkg::QCNT_W'(etfs_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == etfs_pkg::QPTR_W'(etfs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + etfs_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == etfs_pkg::QPTR_W'(etfs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + etfs_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + etfs_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - etfs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // checks
   `ETFS_ASSERT_ALWAYS(a_fill_bound, clock, reset, count_ff <= etfs_pkg::QCNT_W'(etfs_pkg::QUEUE_DEPTH), "queue fill above depth")
   `ETFS_ASSERT_IMP(a_no_push_full, clock, reset, push, !full, "job pushed into full queue")
   `ETFS_ASSERT_NXT(a_push_fills, clock, reset, push && !pop && !full, !empty, "queue empty after push")

endmodule

>>> rtl/etfs_back.sv
// back part: resolves offset priority with the remembered offset, forms the
// verdict and holds it in the result register; uses etfs_pkg
`include "ethertype_tag_skip_filter_macros.svh"
module etfs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_empty,
   input  etfs_pkg::verdict_job_type  job_in,
   output logic                       job_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output etfs_pkg::rsp_type          rsp_data
);

   logic [etfs_pkg::OFFSET_W-1:0] rem_ff, rem_in;
   logic                          out_valid_ff, out_valid_in;
   etfs_pkg::rsp_type             out_ff, out_in;
   logic                          take;
   logic                          scan_hit;
   logic [etfs_pkg::OFFSET_W-1:0] scan_off;
   logic [etfs_pkg::OFFSET_W-1:0] off;
   logic                          found;
   logic [etfs_pkg::COUNT_W-1:0]  off_ext;

   // take a job when the result register is free or being emptied
   assign take    = !job_empty && (!out_valid_ff || rsp_pop);
   assign job_pop = take;

   // lowest matching offset from 1 upward
   always_comb begin
      scan_hit = 1'b0;
      scan_off = '0;
      for (int k = etfs_pkg::MAX_SCAN_OFFSET; k >= 1; k--) begin
         if (job_in.match_vec[k]) begin
            scan_hit = 1'b1;
            scan_off = etfs_pkg::OFFSET_W'(k);
         end
      end
   end

   // priority: offset zero, then the remembered offset, then the scan
   always_comb begin
      rem_in = rem_ff;
      found  = 1'b1;
      off    = '0;
      if (job_in.match_vec[0]) begin
         off = '0;
      end else if (job_in.match_vec[rem_ff]) begin
         off = rem_ff;
      end else if (scan_hit) begin
         off = scan_off;
         if (take) begin
            rem_in = scan_off;
         end
      end else begin
         found = 1'b0;
      end
   end

   // verdict with length saturating at zero
   assign off_ext = etfs_pkg::COUNT_W'(off);
   always_comb begin
      out_in.accept       = found;
      out_in.tag_offset   = found ? off : '0;
      out_in.frame_length = '0;
      if (found && (job_in.byte_count > off_ext)) begin
         out_in.frame_length = etfs_pkg::LENGTH_W'(job_in.byte_count - off_ext);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // checks
   `ETFS_ASSERT_ALWAYS(a_rem_range, clock, reset, rem_ff <= etfs_pkg::OFFSET_W'(etfs_pkg::MAX_SCAN_OFFSET), "remembered offset out of scan range")
   `ETFS_ASSERT_NXT(a_rem_hold, clock, reset, !take, $stable(rem_ff), "remembered offset moved without a verdict")
   `ETFS_ASSERT_IMP(a_drop_zero, clock, reset, out_valid_ff && !out_ff.accept, (out_ff.tag_offset == '0) && (out_ff.frame_length == '0), "dropped frame with nonzero fields")

endmodule

>>> tb/sv/etfs_checker.sv
`timescale 1ns / 100ps
// verdict checker for the ethertype tag skip filter: watches both queue ports,
// predicts each frame verdict and compares it with what the block hands out
// depends on etfs_pkg for the item types, sizes and byte codes
module etfs_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  etfs_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  etfs_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import etfs_pkg::*;

   // predicted state of the block
   logic [7:0]          hdr_bytes [HDR_DEPTH];
   logic [COUNT_W-1:0]  rx_count;
   logic [OFFSET_W-1:0] sticky_offset;
   rsp_type             verdict_q [$];
   int                  fail_total = 0;
   int                  waiting = 0;

   assign fail_count = fail_total;
   assign pending    = waiting;

   // header byte, zero outside the window
   function automatic logic [7:0] hdr_byte_at(int pos);
      if (pos < HDR_DEPTH) begin
         return hdr_bytes[pos];
      end
      return 8'h00;
   endfunction

   // ipv4 or arp signature found at tag offset k
   function automatic logic sig_hit_at(int k);
      logic [7:0] type_lo;
      logic [7:0] prot_hi;
      if (hdr_byte_at(TYPE_POS + k) != ETH_TYPE_HI) begin
         return 1'b0;
      end
      type_lo = hdr_byte_at(TYPE_POS + 1 + k);
      if (type_lo == ETH_TYPE_IP && hdr_byte_at(IP_VER_POS + k) == IPV4_VER_IHL) begin
         return 1'b1;
      end
      if (type_lo != ETH_TYPE_ARP) begin
         return 1'b0;
      end
      prot_hi = hdr_byte_at(ARP_PROT_POS + k);
      return (prot_hi == ARP_PROT_IP || prot_hi == ARP_PROT_ALT) &&
             hdr_byte_at(ARP_PROT_POS + 1 + k) == ARP_PROT_LO;
   endfunction

   task automatic clear_frame();
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_bytes[i] = 8'h00;
      end
      rx_count = '0;
   endtask

   // take one accepted byte, predict a verdict on the final byte
   task automatic take_byte(req_type item);
      rsp_type verdict;
      logic    found;
      int      off;
      found = 1'b0;
      off   = 0;
      if (rx_count < HDR_DEPTH) begin
         hdr_bytes[rx_count] = item.data_byte;
      end
      if (rx_count < MAX_FRAME_BYTES) begin
         rx_count = rx_count + 1'b1;
      end
      if (item.last_byte) begin
         // offset zero first, then the remembered one, then a scan
         if (sig_hit_at(0)) begin
            found = 1'b1;
         end else if (sig_hit_at(int'(sticky_offset))) begin
            found = 1'b1;
            off   = int'(sticky_offset);
         end else begin
            for (int k = 1; k <= MAX_SCAN_OFFSET; k++) begin
               if (!found && sig_hit_at(k)) begin
                  found         = 1'b1;
                  off           = k;
                  sticky_offset = k[OFFSET_W-1:0];
               end
            end
         end
         verdict = '0;
         if (found) begin
            verdict.accept       = 1'b1;
            verdict.tag_offset   = off[OFFSET_W-1:0];
            verdict.frame_length = LENGTH_W'((int'(rx_count) > off) ?
                                             int'(rx_count) - off : 0);
         end
         verdict_q.push_back(verdict);
         clear_frame();
      end
   endtask

   // compare one popped verdict with the oldest prediction
   task automatic check_verdict(rsp_type got);
      rsp_type want;
      if (verdict_q.size() == 0) begin
         fail_total++;
         if (fail_total <= 10) begin
            $display("%0t: verdict with none predicted: accept %0d offset %0d length %0d",
                     $realtime, got.accept, got.tag_offset, got.frame_length);
         end
         return;
      end
      want = verdict_q.pop_front();
      if (got.accept !== want.accept || got.tag_offset !== want.tag_offset ||
          got.frame_length !== want.frame_length) begin
         fail_total++;
         if (fail_total <= 10) begin
            $display({"%0t: verdict mismatch: expected accept %0d offset %0d length %0d,",
                      " got accept %0d offset %0d length %0d"},
                     $realtime, want.accept, want.tag_offset, want.frame_length,
                     got.accept, got.tag_offset, got.frame_length);
         end
      end
   endtask

   // results first, so a verdict never meets a prediction made this edge
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         sticky_offset = '0;
         verdict_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_verdict(rsp_data);
         end
         if (req_push && !req_full) begin
            take_byte(req_data);
         end
      end
      waiting = verdict_q.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// top of the ethertype tag skip filter testbench: clock, reset, frame stimulus
// and receiver stalls; depends on etfs_pkg, etfs_checker and the block itself
module testbench;
   import etfs_pkg::*;

   typedef enum int {
      FRM_IPV4,
      FRM_ARP_IP,
      FRM_ARP_ALT,
      FRM_NEAR,
      FRM_NOISE
   } frame_kind_type;

   localparam int BUF_BYTES   = 2112;
   localparam int RANDOM_BYTES = 1650;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    rsp_pop  = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   logic [7:0] frame_buf [BUF_BYTES];
   int         frame_len;
   int         burst_left = 0;
   int         bytes_sent = 0;
   int         fav_offset = 0;
   int         rx_mode    = 0;
   int         rx_left    = 0;

   always #5 clock = ~clock;

   ethertype_tag_skip_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   etfs_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver: always pops, pops at random, or stalls for long stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom_range(0, 1));
            default: rsp_pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // one item, sent in bursts with idle gaps between them
   task automatic push_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 3) != 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= '{data_byte: b, last_byte: last};
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_len; i++) begin
         push_byte(frame_buf[i], i == frame_len - 1);
      end
   endtask

   // random bytes with a signature, a damaged signature or nothing at the offset
   task automatic build_frame(frame_kind_type kind, int off, int len);
      int base;
      int pos;
      bit use_arp;
      base    = TYPE_POS + off;
      use_arp = 1'($urandom_range(0, 1));
      for (int i = 0; i < BUF_BYTES; i++) begin
         frame_buf[i] = 8'($urandom_range(0, 255));
      end
      if (kind == FRM_IPV4 || (kind == FRM_NEAR && !use_arp)) begin
         frame_buf[base]     = ETH_TYPE_HI;
         frame_buf[base + 1] = ETH_TYPE_IP;
         frame_buf[base + 2] = IPV4_VER_IHL;
      end else if (kind != FRM_NOISE) begin
         frame_buf[base]     = ETH_TYPE_HI;
         frame_buf[base + 1] = ETH_TYPE_ARP;
         frame_buf[base + 4] = (kind == FRM_ARP_ALT || (kind == FRM_NEAR &&
                               $urandom_range(0, 1))) ? ARP_PROT_ALT : ARP_PROT_IP;
         frame_buf[base + 5] = ARP_PROT_LO;
      end
      // near miss: flip bits in one signature byte
      if (kind == FRM_NEAR) begin
         if (use_arp) begin
            pos = $urandom_range(0, 3);
            pos = (pos > 1) ? pos + 2 : pos;
         end else begin
            pos = $urandom_range(0, 2);
         end
         frame_buf[base + pos] = frame_buf[base + pos] ^ 8'($urandom_range(1, 255));
      end
      frame_len = len;
   endtask

   task automatic random_frame();
      frame_kind_type kind;
      int pick;
      int off;
      int needed;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = FRM_IPV4;
      else if (pick < 45) kind = FRM_ARP_IP;
      else if (pick < 60) kind = FRM_ARP_ALT;
      else if (pick < 80) kind = FRM_NEAR;
      else kind = FRM_NOISE;
      // mostly a favored offset so the remembered offset gets hit
      pick = $urandom_range(0, 9);
      if (pick < 6) off = fav_offset;
      else if (pick < 9) off = $urandom_range(0, MAX_SCAN_OFFSET);
      else off = $urandom_range(MAX_SCAN_OFFSET + 1, MAX_SCAN_OFFSET + 3);
      needed = TYPE_POS + off + ((kind == FRM_IPV4) ? 3 : 6);
      pick = $urandom_range(0, 9);
      if (kind == FRM_NOISE) len = $urandom_range(1, 70);
      else if (pick == 0) len = $urandom_range(1, needed - 1);
      else if (pick == 1) len = needed;
      else len = needed + $urandom_range(0, 50);
      build_frame(kind, off, len);
      send_frame();
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int frames;
      int next_pause;
      frames     = 0;
      next_pause = 400;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one-byte frames at both byte extremes
      frame_buf[0] = 8'hFF;
      frame_len    = 1;
      send_frame();
      frame_buf[0] = 8'h00;
      send_frame();
      // shortest ipv4 frame at offset zero, all other bytes set
      for (int i = 0; i < 15; i++) begin
         frame_buf[i] = 8'hFF;
      end
      frame_buf[TYPE_POS]     = ETH_TYPE_HI;
      frame_buf[TYPE_POS + 1] = ETH_TYPE_IP;
      frame_buf[IP_VER_POS]   = IPV4_VER_IHL;
      frame_len = 15;
      send_frame();
      // short frame of zeros, the window past it reads zero
      for (int i = 0; i < 7; i++) begin
         frame_buf[i] = 8'h00;
      end
      frame_len = 7;
      send_frame();

      // random frames
      while (bytes_sent < RANDOM_BYTES) begin
         if (frames % 12 == 0) begin
            fav_offset = $urandom_range(0, MAX_SCAN_OFFSET);
         end
         random_frame();
         frames++;
         // hold off until every verdict is out
         if (bytes_sent >= next_pause) begin
            drain();
            next_pause = bytes_sent + 400;
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> ethertype_tag_skip_filter.f
+incdir+rtl
rtl/etfs_pkg.sv
rtl/etfs_front.sv
rtl/etfs_queue.sv
rtl/etfs_back.sv
rtl/ethertype_tag_skip_filter.sv
tb/sv/etfs_checker.sv
tb/sv/testbench.sv
